@@ hdl/fud_pkg.sv @@
// Shared types, codes and character helpers for the file URI path decoder.
package fud_pkg;

    localparam int CAP_W = 13;
    localparam int CAP_MAX_REG = (1 << CAP_W) - 1;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SCHEME    = 4'd1;
    localparam logic [3:0] ST_AUTH_CHAR = 4'd2;
    localparam logic [3:0] ST_NONLOCAL  = 4'd3;
    localparam logic [3:0] ST_NO_PATH   = 4'd4;
    localparam logic [3:0] ST_BAD_CHAR  = 4'd5;
    localparam logic [3:0] ST_BAD_ESC   = 4'd6;
    localparam logic [3:0] ST_FORBIDDEN = 4'd7;
    localparam logic [3:0] ST_OVERFLOW  = 4'd8;

    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_QUESTION  = 8'h3F;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DEL       = 8'h7F;

    // "file:"
    localparam logic [7:0] SCHEME_TEXT [5] = '{8'h66, 8'h69, 8'h6C, 8'h65, 8'h3A};
    // "localhost"
    localparam logic [7:0] HOST_TEXT [9] =
        '{8'h6C, 8'h6F, 8'h63, 8'h61, 8'h6C, 8'h68, 8'h6F, 8'h73, 8'h74};
    localparam logic [3:0] HOST_LEN = 4'd9;
    localparam logic [3:0] HOST_SAT = 4'd10;

    typedef enum logic [7:0] {
        PH_SCHEME      = 8'b0000_0001,
        PH_AFTER_COLON = 8'b0000_0010,
        PH_SLASH1      = 8'b0000_0100,
        PH_AUTH        = 8'b0000_1000,
        PH_PATH        = 8'b0001_0000,
        PH_ESC1        = 8'b0010_0000,
        PH_ESC2        = 8'b0100_0000,
        PH_FAILED      = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] uri_byte;
        logic       end_of_uri;
    } in_t;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       is_status;
        logic [3:0] status;
        logic       last;
    } out_t;

    // Up to three result beats produced by one input beat
    typedef struct packed {
        logic [1:0]     cnt;
        out_t [2:0]     item;
    } push_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c | 8'h20;
        end
        return c;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] l;
        l = to_lower(c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, 4'(c - 8'h30)};
        end
        if (l >= 8'h61 && l <= 8'h66) begin
            return {1'b1, 4'(l - 8'h57)};
        end
        return 5'd0;
    endfunction

    function automatic logic bad_path_char(input logic [7:0] c);
        return (c < CH_SPACE) || (c == CH_DEL) || (c == CH_QUESTION) ||
               (c == CH_HASH) || (c == CH_BACKSLASH);
    endfunction

    function automatic out_t mk_byte(input logic [7:0] c);
        out_t o;
        o.path_byte = c;
        o.is_status = 1'b0;
        o.status    = ST_OK;
        o.last      = 1'b0;
        return o;
    endfunction

    function automatic out_t mk_status(input logic [3:0] st);
        out_t o;
        o.path_byte = 8'd0;
        o.is_status = 1'b1;
        o.status    = st;
        o.last      = 1'b1;
        return o;
    endfunction

endpackage

@@ hdl/file_uri_path_decoder.sv @@
// Top level of the file URI to POSIX path decoder.
//
// s_valid/s_ready/s_data carry one raw URI byte per beat; end_of_uri marks the
// final byte of a URI. m_valid/m_ready/m_data carry decoded path bytes and,
// on the beat with last set, one status beat per URI (0 means success; on any
// other status the receiver drops the bytes it already took for that URI).
// cfg_valid/cfg_ready/cfg_data write the output capacity; at most capacity
// minus one bytes are emitted per URI. cfg_ready is always high.
//
// An accepted byte is held in the input register and decoded into the result
// queue, whose head drives m_data. Throughput: one input beat per cycle while
// the queue has room; the single-pass decoder writes up to three beats into a
// four-entry result queue, which drains one beat per cycle while m_ready is
// high. Extra beats collect in the queue, and s_ready drops when the held byte
// cannot fire for lack of three free slots. Reset clears the parse state and
// the queue and sets the capacity to 4096 (clamped to MAX_CAPACITY). When
// m_ready stays low, the queue fills and s_ready drops; nothing is lost.
module file_uri_path_decoder #(
    parameter int MAX_CAPACITY = 4096
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  fud_pkg::in_t                s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output fud_pkg::out_t               m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fud_pkg::CAP_W-1:0]   cfg_data
);

    localparam int CLAMP = (MAX_CAPACITY > fud_pkg::CAP_MAX_REG) ?
                           fud_pkg::CAP_MAX_REG : MAX_CAPACITY;
    localparam logic [fud_pkg::CAP_W-1:0] CLAMP_V   = fud_pkg::CAP_W'(CLAMP);
    localparam int RESET_CAP = (4096 > CLAMP) ? CLAMP : 4096;
    localparam logic [fud_pkg::CAP_W-1:0] RESET_LIMIT = fud_pkg::CAP_W'(RESET_CAP - 1);

    logic                        in_valid_reg;
    fud_pkg::in_t                in_data_reg;
    logic [fud_pkg::CAP_W-1:0]   limit_reg, limit_next;
    logic                        fire;
    logic                        room;
    fud_pkg::push_t              push;

    assign fire      = in_valid_reg && room;
    assign s_ready   = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    always_comb begin
        if (cfg_data > CLAMP_V) begin
            limit_next = CLAMP_V - 1'b1;
        end else if (cfg_data == '0) begin
            limit_next = '0;
        end else begin
            limit_next = cfg_data - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= RESET_LIMIT;
        end else if (cfg_valid) begin
            limit_reg <= limit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    fud_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .in_data (in_data_reg),
        .limit   (limit_reg),
        .push    (push)
    );

    fud_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ hdl/fud_parser.sv @@
// Parse state and single-pass decode of one URI byte into up to three result beats.
module fud_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        fire,
    input  fud_pkg::in_t                in_data,
    input  logic [fud_pkg::CAP_W-1:0]   limit,
    output fud_pkg::push_t              push
);

    fud_pkg::phase_t              phase_reg, phase_next;
    logic [3:0]                   pos_reg, pos_next;
    logic                         hm_reg, hm_next;
    logic [3:0]                   hi_reg, hi_next;
    logic [fud_pkg::CAP_W-1:0]    bw_reg, bw_next;
    logic [3:0]                   err_reg, err_next;

    fud_pkg::out_t                items [0:2];
    logic [1:0]                   n;
    logic [7:0]                   b;
    logic [7:0]                   bl;
    logic [4:0]                   hx;
    logic [7:0]                   v;
    logic [3:0]                   st;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        hm_next    = hm_reg;
        hi_next    = hi_reg;
        bw_next    = bw_reg;
        err_next   = err_reg;
        n          = 2'd0;
        items[0]   = '0;
        items[1]   = '0;
        items[2]   = '0;
        b          = in_data.uri_byte;
        bl         = fud_pkg::to_lower(b);
        hx         = fud_pkg::hex_decode(b);
        v          = {hi_reg, hx[3:0]};
        st         = fud_pkg::ST_OK;

        unique case (phase_reg)
            fud_pkg::PH_SCHEME: begin
                if (bl != fud_pkg::SCHEME_TEXT[pos_reg[2:0]]) begin
                    phase_next = fud_pkg::PH_FAILED;
                    err_next   = fud_pkg::ST_SCHEME;
                end else if (pos_reg == 4'd4) begin
                    pos_next   = 4'd0;
                    phase_next = fud_pkg::PH_AFTER_COLON;
                end else begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            fud_pkg::PH_AFTER_COLON: begin
                if (b == fud_pkg::CH_SLASH) begin
                    phase_next = fud_pkg::PH_SLASH1;
                end else begin
                    phase_next = fud_pkg::PH_FAILED;
                    err_next   = fud_pkg::ST_NO_PATH;
                end
            end
            fud_pkg::PH_SLASH1: begin
                if (b == fud_pkg::CH_SLASH) begin
                    phase_next = fud_pkg::PH_AUTH;
                    pos_next   = 4'd0;
                    hm_next    = 1'b1;
                end else begin
                    phase_next = fud_pkg::PH_PATH;
                    // pending slash goes out ahead of this byte
                    if (bw_next < limit) begin
                        items[n] = fud_pkg::mk_byte(fud_pkg::CH_SLASH);
                        n        = n + 2'd1;
                        bw_next  = bw_next + 1'b1;
                    end else begin
                        phase_next = fud_pkg::PH_FAILED;
                        err_next   = fud_pkg::ST_OVERFLOW;
                    end
                    if (phase_next == fud_pkg::PH_PATH) begin
                        if (fud_pkg::bad_path_char(b)) begin
                            phase_next = fud_pkg::PH_FAILED;
                            err_next   = fud_pkg::ST_BAD_CHAR;
                        end else if (b == fud_pkg::CH_PERCENT) begin
                            phase_next = fud_pkg::PH_ESC1;
                        end else if (bw_next < limit) begin
                            items[n] = fud_pkg::mk_byte(b);
                            n        = n + 2'd1;
                            bw_next  = bw_next + 1'b1;
                        end else begin
                            phase_next = fud_pkg::PH_FAILED;
                            err_next   = fud_pkg::ST_OVERFLOW;
                        end
                    end
                end
            end
            fud_pkg::PH_AUTH: begin
                if (b == fud_pkg::CH_QUESTION || b == fud_pkg::CH_HASH ||
                    b == fud_pkg::CH_BACKSLASH) begin
                    phase_next = fud_pkg::PH_FAILED;
                    err_next   = fud_pkg::ST_AUTH_CHAR;
                end else if (b == fud_pkg::CH_SLASH) begin
                    if (pos_reg == 4'd0 || (pos_reg == fud_pkg::HOST_LEN && hm_reg)) begin
                        phase_next = fud_pkg::PH_PATH;
                        if (bw_next < limit) begin
                            items[n] = fud_pkg::mk_byte(fud_pkg::CH_SLASH);
                            n        = n + 2'd1;
                            bw_next  = bw_next + 1'b1;
                        end else begin
                            phase_next = fud_pkg::PH_FAILED;
                            err_next   = fud_pkg::ST_OVERFLOW;
                        end
                    end else begin
                        phase_next = fud_pkg::PH_FAILED;
                        err_next   = fud_pkg::ST_NONLOCAL;
                    end
                end else begin
                    if (pos_reg >= fud_pkg::HOST_LEN) begin
                        hm_next = 1'b0;
                    end else if (bl != fud_pkg::HOST_TEXT[pos_reg]) begin
                        hm_next = 1'b0;
                    end
                    if (pos_reg < fud_pkg::HOST_SAT) begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
            end
            fud_pkg::PH_PATH: begin
                if (fud_pkg::bad_path_char(b)) begin
                    phase_next = fud_pkg::PH_FAILED;
                    err_next   = fud_pkg::ST_BAD_CHAR;
                end else if (b == fud_pkg::CH_PERCENT) begin
                    phase_next = fud_pkg::PH_ESC1;
                end else if (bw_next < limit) begin
                    items[n] = fud_pkg::mk_byte(b);
                    n        = n + 2'd1;
                    bw_next  = bw_next + 1'b1;
                end else begin
                    phase_next = fud_pkg::PH_FAILED;
                    err_next   = fud_pkg::ST_OVERFLOW;
                end
            end
            fud_pkg::PH_ESC1: begin
                if (!hx[4]) begin
                    phase_next = fud_pkg::PH_FAILED;
                    err_next   = fud_pkg::ST_BAD_ESC;
                end else begin
                    hi_next    = hx[3:0];
                    phase_next = fud_pkg::PH_ESC2;
                end
            end
            fud_pkg::PH_ESC2: begin
                if (!hx[4]) begin
                    phase_next = fud_pkg::PH_FAILED;
                    err_next   = fud_pkg::ST_BAD_ESC;
                end else if (v == 8'd0 || v == fud_pkg::CH_SLASH ||
                             v == fud_pkg::CH_BACKSLASH) begin
                    phase_next = fud_pkg::PH_FAILED;
                    err_next   = fud_pkg::ST_FORBIDDEN;
                end else begin
                    phase_next = fud_pkg::PH_PATH;
                    if (bw_next < limit) begin
                        items[n] = fud_pkg::mk_byte(v);
                        n        = n + 2'd1;
                        bw_next  = bw_next + 1'b1;
                    end else begin
                        phase_next = fud_pkg::PH_FAILED;
                        err_next   = fud_pkg::ST_OVERFLOW;
                    end
                end
            end
            default: begin
            end
        endcase

        if (in_data.end_of_uri) begin
            case (phase_next) inside
                fud_pkg::PH_SCHEME, fud_pkg::PH_AFTER_COLON: begin
                    st = fud_pkg::ST_SCHEME;
                end
                fud_pkg::PH_SLASH1: begin
                    if (bw_next < limit) begin
                        items[n] = fud_pkg::mk_byte(fud_pkg::CH_SLASH);
                        n        = n + 2'd1;
                        st       = fud_pkg::ST_OK;
                    end else begin
                        st = fud_pkg::ST_OVERFLOW;
                    end
                end
                fud_pkg::PH_AUTH: begin
                    st = fud_pkg::ST_NO_PATH;
                end
                fud_pkg::PH_PATH: begin
                    st = fud_pkg::ST_OK;
                end
                fud_pkg::PH_ESC1, fud_pkg::PH_ESC2: begin
                    st = fud_pkg::ST_BAD_ESC;
                end
                default: begin
                    st = err_next;
                end
            endcase
            items[n]   = fud_pkg::mk_status(st);
            n          = n + 2'd1;
            phase_next = fud_pkg::PH_SCHEME;
            pos_next   = 4'd0;
            hm_next    = 1'b1;
            hi_next    = 4'd0;
            bw_next    = '0;
            err_next   = fud_pkg::ST_OK;
        end

        push.cnt     = fire ? n : 2'd0;
        push.item[0] = items[0];
        push.item[1] = items[1];
        push.item[2] = items[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= fud_pkg::PH_SCHEME;
            pos_reg   <= 4'd0;
            hm_reg    <= 1'b1;
            hi_reg    <= 4'd0;
            bw_reg    <= '0;
            err_reg   <= fud_pkg::ST_OK;
        end else if (fire) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            hm_reg    <= hm_next;
            hi_reg    <= hi_next;
            bw_reg    <= bw_next;
            err_reg   <= err_next;
        end
    end

endmodule

@@ hdl/fud_out_fifo.sv @@
// Four-entry result queue: takes up to three beats per cycle, drains one per cycle while m_ready is high.
module fud_out_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  fud_pkg::push_t  push,
    output logic            room,
    output logic            m_valid,
    input  logic            m_ready,
    output fud_pkg::out_t   m_data
);

    fud_pkg::out_t mem_reg [4];
    logic [1:0]    wr_ptr_reg, wr_ptr_next;
    logic [1:0]    rd_ptr_reg, rd_ptr_next;
    logic [2:0]    count_reg, count_next;
    logic          pop;

    assign m_valid = (count_reg != 3'd0);
    assign m_data  = mem_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    // three free slots after this cycle's pop
    assign room    = (count_reg <= 3'd1) || (count_reg == 3'd2 && pop);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push.cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.cnt} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < push.cnt) begin
                mem_reg[wr_ptr_reg + 2'(k)] <= push.item[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sim/file_uri_path_decoder_tb.sv @@
// Self-checking testbench for the file URI path decoder: directed and random URIs against a local predictor.
module file_uri_path_decoder_tb;

    localparam int CAP_LIMIT = 4096;
    localparam logic [7:0] SCHEME_CHARS [5] = '{8'h66, 8'h69, 8'h6C, 8'h65, 8'h3A};
    localparam logic [7:0] HOST_CHARS [9] =
        '{8'h6C, 8'h6F, 8'h63, 8'h61, 8'h6C, 8'h68, 8'h6F, 8'h73, 8'h74};
    localparam logic [fud_pkg::CAP_W-1:0] CAP_PLAN [8] =
        '{13'd0, 13'd8191, 13'd2, 13'd7, 13'd1, 13'd4096, 13'd12, 13'd5};

    typedef logic [7:0] byte_q_t[$];

    class path_decode_scoreboard;
        logic [fud_pkg::CAP_W-1:0] capacity;
        fud_pkg::phase_t           phase;
        logic [3:0]                match_pos;
        logic                      host_ok;
        logic [3:0]                esc_hi;
        int unsigned               written;
        logic [3:0]                err_code;
        fud_pkg::out_t             predicted_beats[$];
        int unsigned               failures;

        function new();
            capacity = fud_pkg::CAP_W'(CAP_LIMIT);
            failures = 0;
            restart();
        endfunction

        function void restart();
            phase     = fud_pkg::PH_SCHEME;
            match_pos = 4'd0;
            host_ok   = 1'b1;
            esc_hi    = 4'd0;
            written   = 0;
            err_code  = fud_pkg::ST_OK;
        endfunction

        function void abort(logic [3:0] code);
            err_code = code;
            phase    = fud_pkg::PH_FAILED;
        endfunction

        function logic [7:0] fold(logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
        endfunction

        function int nibble_of(logic [7:0] c);
            logic [7:0] l;
            l = fold(c);
            if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
            if (l >= 8'h61 && l <= 8'h66) return int'(l - 8'h57);
            return -1;
        endfunction

        function void push_byte(logic [7:0] c);
            int unsigned lim;
            lim = (capacity > CAP_LIMIT) ? CAP_LIMIT : int'(capacity);
            if (lim == 0) lim = 1;
            if (written + 1 >= lim) begin
                abort(fud_pkg::ST_OVERFLOW);
                return;
            end
            predicted_beats.push_back(fud_pkg::out_t'{c, 1'b0, fud_pkg::ST_OK, 1'b0});
            written++;
        endfunction

        function void path_char(logic [7:0] c);
            if (c < fud_pkg::CH_SPACE || c == fud_pkg::CH_DEL || c == fud_pkg::CH_QUESTION ||
                c == fud_pkg::CH_HASH || c == fud_pkg::CH_BACKSLASH) begin
                abort(fud_pkg::ST_BAD_CHAR);
            end else if (c == fud_pkg::CH_PERCENT) begin
                phase = fud_pkg::PH_ESC1;
            end else begin
                push_byte(c);
            end
        endfunction

        function void decode_uri_byte(fud_pkg::in_t d);
            logic [7:0] b;
            logic [7:0] v;
            logic [3:0] st;
            int         h;
            b = d.uri_byte;
            case (phase)
                fud_pkg::PH_SCHEME: begin
                    if (match_pos > 4 || fold(b) != SCHEME_CHARS[match_pos]) begin
                        abort(fud_pkg::ST_SCHEME);
                    end else if (match_pos == 4) begin
                        match_pos = 4'd0;
                        phase = fud_pkg::PH_AFTER_COLON;
                    end else begin
                        match_pos++;
                    end
                end
                fud_pkg::PH_AFTER_COLON: begin
                    if (b == fud_pkg::CH_SLASH) phase = fud_pkg::PH_SLASH1;
                    else abort(fud_pkg::ST_NO_PATH);
                end
                fud_pkg::PH_SLASH1: begin
                    if (b == fud_pkg::CH_SLASH) begin
                        phase = fud_pkg::PH_AUTH;
                        match_pos = 4'd0;
                        host_ok = 1'b1;
                    end else begin
                        phase = fud_pkg::PH_PATH;
                        push_byte(fud_pkg::CH_SLASH);
                        if (phase == fud_pkg::PH_PATH) path_char(b);
                    end
                end
                fud_pkg::PH_AUTH: begin
                    if (b == fud_pkg::CH_QUESTION || b == fud_pkg::CH_HASH ||
                        b == fud_pkg::CH_BACKSLASH) begin
                        abort(fud_pkg::ST_AUTH_CHAR);
                    end else if (b == fud_pkg::CH_SLASH) begin
                        if (match_pos == 0 || (match_pos == 9 && host_ok)) begin
                            phase = fud_pkg::PH_PATH;
                            push_byte(fud_pkg::CH_SLASH);
                        end else begin
                            abort(fud_pkg::ST_NONLOCAL);
                        end
                    end else begin
                        if (match_pos >= 9 || fold(b) != HOST_CHARS[match_pos]) begin
                            host_ok = 1'b0;
                        end
                        if (match_pos < 10) match_pos++;
                    end
                end
                fud_pkg::PH_PATH: path_char(b);
                fud_pkg::PH_ESC1: begin
                    h = nibble_of(b);
                    if (h < 0) begin
                        abort(fud_pkg::ST_BAD_ESC);
                    end else begin
                        esc_hi = h[3:0];
                        phase = fud_pkg::PH_ESC2;
                    end
                end
                fud_pkg::PH_ESC2: begin
                    h = nibble_of(b);
                    if (h < 0) begin
                        abort(fud_pkg::ST_BAD_ESC);
                    end else begin
                        v = {esc_hi, h[3:0]};
                        if (v == 8'h00 || v == fud_pkg::CH_SLASH ||
                            v == fud_pkg::CH_BACKSLASH) begin
                            abort(fud_pkg::ST_FORBIDDEN);
                        end else begin
                            phase = fud_pkg::PH_PATH;
                            push_byte(v);
                        end
                    end
                end
                default: ;
            endcase

            if (d.end_of_uri) begin
                case (phase)
                    fud_pkg::PH_SCHEME, fud_pkg::PH_AFTER_COLON: st = fud_pkg::ST_SCHEME;
                    fud_pkg::PH_SLASH1: begin
                        push_byte(fud_pkg::CH_SLASH);
                        st = (phase == fud_pkg::PH_FAILED) ? err_code : fud_pkg::ST_OK;
                    end
                    fud_pkg::PH_AUTH: st = fud_pkg::ST_NO_PATH;
                    fud_pkg::PH_PATH: st = fud_pkg::ST_OK;
                    fud_pkg::PH_ESC1, fud_pkg::PH_ESC2: st = fud_pkg::ST_BAD_ESC;
                    default: st = err_code;
                endcase
                predicted_beats.push_back(fud_pkg::out_t'{8'h00, 1'b1, st, 1'b1});
                restart();
            end
        endfunction

        function string show(fud_pkg::out_t r);
            return $sformatf("byte %02h is_status %0d status %0d last %0d",
                             r.path_byte, r.is_status, r.status, r.last);
        endfunction

        function void complain(string msg);
            failures++;
            if (failures <= 10) $display("%0t: %s", $time, msg);
        endfunction

        function void check_path_beat(fud_pkg::out_t got);
            fud_pkg::out_t want;
            if (predicted_beats.size() == 0) begin
                complain({"unexpected beat: ", show(got)});
                return;
            end
            want = predicted_beats.pop_front();
            if (got.path_byte !== want.path_byte || got.is_status !== want.is_status ||
                got.status !== want.status || got.last !== want.last) begin
                complain({"expected ", show(want), ", got ", show(got)});
            end
        endfunction
    endclass

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    fud_pkg::in_t              s_data    = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    fud_pkg::out_t             m_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [fud_pkg::CAP_W-1:0] cfg_data  = '0;

    int send_idle = 19;
    int recv_idle = 72;
    path_decode_scoreboard sb;

    file_uri_path_decoder #(.MAX_CAPACITY(CAP_LIMIT)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_path_beat(m_data);
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic logic [7:0] shuffle_case(logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1) == 1) return c ^ 8'h20;
        return c;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return 8'h30 + {4'h0, n};
        return ($urandom_range(1) == 1 ? 8'h37 : 8'h57) + {4'h0, n};
    endfunction

    function automatic void add_host(ref byte_q_t u);
        int pick;
        pick = $urandom_range(99);
        if (pick < 20) return;
        if (pick < 55) begin
            for (int i = 0; i < 9; i++) u.push_back(shuffle_case(HOST_CHARS[i]));
            if ($urandom_range(3) == 0) u.push_back(8'($urandom_range(8'h61, 8'h7A)));
        end else if (pick < 70) begin
            for (int i = 0; i < $urandom_range(1, 8); i++) u.push_back(shuffle_case(HOST_CHARS[i]));
        end else if (pick < 90) begin
            repeat ($urandom_range(1, 11)) begin
                u.push_back(8'($urandom_range(8'h30, 8'h7E)));
            end
        end else begin
            repeat ($urandom_range(0, 3)) u.push_back(8'($urandom_range(8'h61, 8'h7A)));
            case ($urandom_range(2))
                0: u.push_back(fud_pkg::CH_QUESTION);
                1: u.push_back(fud_pkg::CH_HASH);
                default: u.push_back(fud_pkg::CH_BACKSLASH);
            endcase
            repeat ($urandom_range(0, 2)) u.push_back(8'($urandom_range(8'h61, 8'h7A)));
        end
    endfunction

    function automatic void add_path(ref byte_q_t u);
        int         pick;
        logic [7:0] v;
        repeat ($urandom_range(0, 8)) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                u.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end else if (pick < 80) begin
                v = 8'($urandom);
                if ($urandom_range(9) == 0) begin
                    case ($urandom_range(2))
                        0: v = 8'h00;
                        1: v = fud_pkg::CH_SLASH;
                        default: v = fud_pkg::CH_BACKSLASH;
                    endcase
                end
                u.push_back(fud_pkg::CH_PERCENT);
                u.push_back(hex_char(v[7:4]));
                u.push_back(hex_char(v[3:0]));
                if ($urandom_range(19) == 0) begin
                    u[u.size() - 1 - $urandom_range(1)] = 8'($urandom_range(8'h67, 8'h7A));
                end
            end else if (pick < 92) begin
                u.push_back(fud_pkg::CH_SLASH);
            end else begin
                u.push_back(8'($urandom));
            end
        end
        // escape cut short by the end of the URI
        if ($urandom_range(14) == 0) begin
            u.push_back(fud_pkg::CH_PERCENT);
            if ($urandom_range(1) == 1) u.push_back(hex_char(4'($urandom)));
        end
    endfunction

    function automatic void make_uri(output byte_q_t u);
        int pick;
        u = {};
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 6)) u.push_back(8'($urandom));
            return;
        end
        for (int i = 0; i < 5; i++) u.push_back(shuffle_case(SCHEME_CHARS[i]));
        if (pick < 11) begin
            u = u[0:$urandom_range(0, 4)];
            return;
        end
        if (pick < 14) u[$urandom_range(0, 4)] = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 5) begin
            u.push_back(8'($urandom));
            add_path(u);
            return;
        end
        if (pick < 9) return;
        u.push_back(fud_pkg::CH_SLASH);
        if (pick < 14) return;
        if (pick < 55) begin
            u.push_back(fud_pkg::CH_SLASH);
            add_host(u);
            if ($urandom_range(9) == 0) return;
            u.push_back(fud_pkg::CH_SLASH);
        end
        add_path(u);
    endfunction

    task automatic send_beat(fud_pkg::in_t d);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            s_data  <= 9'($urandom);
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.decode_uri_byte(d);
    endtask

    task automatic send_uri(byte_q_t text);
        foreach (text[i]) begin
            send_beat(fud_pkg::in_t'{text[i], i == text.size() - 1});
        end
    endtask

    task automatic send_string(string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        send_uri(q);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.predicted_beats.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [fud_pkg::CAP_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.capacity = v;
    endtask

    initial begin
        byte_q_t u;
        int      sent;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        u = {};
        u.push_back(8'h00);
        send_uri(u);
        u[0] = 8'hFF;
        send_uri(u);
        send_string("file:/");
        send_string("FiLe:/%4a");
        send_string("fIlE:/?");

        for (int blk = 0; blk < 8; blk++) begin
            drain();
            write_capacity(CAP_PLAN[blk]);
            if (blk < 3) begin
                send_idle = 19;
                recv_idle = 72;
            end else if (blk < 6) begin
                send_idle = 72;
                recv_idle = 19;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            sent = 0;
            while (sent < 37) begin
                make_uri(u);
                send_uri(u);
                sent += u.size();
            end
        end
        drain();
        repeat (6) @(posedge aclk);

        if (sb.failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
